[hdl/lphs_pkg.sv]
// lphs_pkg: sizes, codes and shared types of the linear probing hash set
// no dependencies; used by the channel interfaces and the top level

package lphs_pkg;

    // table geometry
    localparam int SLOTS       = 1024;
    localparam int KEY_BITS    = 32;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int KEY_IN_W    = 32;
    localparam int KEY_W       = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int MIN_SLOTS   = 3;

    // channel field widths
    localparam int CMD_W       = 2;
    localparam int HASH_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_IDX_W  = 10;
    localparam int SKEY_W      = 32;
    localparam int ECNT_W      = 11;

    // register port
    localparam int CFG_W       = 11;
    localparam int RESET_SLOTS = 1021;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int DIV_CW      = $clog2(HASH_W);

    // remainder step width, one bit above the slot count
    localparam int REM_W       = CNT_W + 1;

    typedef enum logic [0:0] {
        REG_ACTIVE_SLOTS = 1'b0
    } t_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

endpackage

[hdl/lphs_cmd_if.sv]
// lphs_cmd_if: command channel of the hash set, valid/ready with payload
// depends on lphs_pkg for field widths

interface lphs_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [lphs_pkg::CMD_W-1:0]     command;
    logic [lphs_pkg::KEY_IN_W-1:0]  key;
    logic [lphs_pkg::HASH_W-1:0]    key_hash;

    modport source (output valid, command, key, key_hash, input ready);
    modport sink (input valid, command, key, key_hash, output ready);
endinterface

[hdl/lphs_rsp_if.sv]
// lphs_rsp_if: result channel of the hash set, valid/ready with payload
// depends on lphs_pkg for field widths

interface lphs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [lphs_pkg::STATUS_W-1:0]    status;
    logic [lphs_pkg::SLOT_IDX_W-1:0]  slot_index;
    logic [lphs_pkg::SKEY_W-1:0]      stored_key;
    logic [lphs_pkg::ECNT_W-1:0]      entry_count;

    modport source (output valid, status, slot_index, stored_key, entry_count, input ready);
    modport sink (input valid, status, slot_index, stored_key, entry_count, output ready);
endinterface

[hdl/linear_probing_hash_set_top.sv]
// linear_probing_hash_set_top: open-addressing key set with linear probing
// depends on lphs_pkg, lphs_cmd_if and lphs_rsp_if
//
// usage
//   i_cmd carries one word per command: insert, remove, lookup or clear, with
//   the key and its externally computed hash. o_rsp returns exactly one word
//   per command: status, slot index, stored key and entry count.
//   active_slots (byte address 0 of the apb port) sets the slot count in use;
//   writing it empties the table.
// timing
//   one command at a time. the home slot (hash modulo slot count) comes from
//   a bit-serial remainder unit, then each probed slot takes a read state and
//   a check state on the table memory.
//   remove then walks the run behind the hole: each entry is read, re-probed
//   from its home and moved back where needed, up to the empty slot that ends it.
//   clear sweeps only the slots in use.
// reset and stalls
//   reset, and every active_slots write, starts a clearing pass over all 1024
//   slots of the memory; no command is taken until it ends.
//   a finished result waits in the output register while the receiver stalls;
//   the next command is already taken and processed meanwhile, and only its
//   own result waits for the register to drain.

module linear_probing_hash_set_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lphs_cmd_if.sink                      i_cmd,
    lphs_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lphs_pkg::ADDR_W-1:0]   paddr,
    input  logic [lphs_pkg::DATA_W-1:0]   pwdata,
    output logic [lphs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_SWEEP = 9'b0_0000_0001,   // clearing pass over the memory
        S_IDLE  = 9'b0_0000_0010,   // waiting for a command word
        S_DIV   = 9'b0_0000_0100,   // hash modulo slot count, one bit a cycle
        S_PRD   = 9'b0_0000_1000,   // probe: read slot
        S_PCHK  = 9'b0_0001_0000,   // probe: check slot
        S_RRD   = 9'b0_0010_0000,   // repair walk: read next run entry
        S_RCHK  = 9'b0_0100_0000,   // repair walk: start re-probe of entry
        S_MOVE  = 9'b0_1000_0000,   // repair walk: empty the old slot
        S_DONE  = 9'b1_0000_0000    // result ready for the output register
    } t_state;

    // one table slot: valid flag, home slot and key
    typedef struct packed {
        logic                         valid;
        logic [lphs_pkg::IDX_W-1:0]   home;
        logic [lphs_pkg::KEY_W-1:0]   key;
    } t_entry;

    // saturate the register value to the usable slot range
    function automatic logic [lphs_pkg::CNT_W-1:0] sat_slots(
        input logic [lphs_pkg::CFG_W-1:0] a
    );
        int v;
        v = int'(a);
        if (v < lphs_pkg::MIN_SLOTS) begin
            v = lphs_pkg::MIN_SLOTS;
        end
        if (v > lphs_pkg::SLOTS) begin
            v = lphs_pkg::SLOTS;
        end
        return lphs_pkg::CNT_W'(v);
    endfunction

    // next slot, wrapping at the slot count in use
    function automatic logic [lphs_pkg::IDX_W-1:0] next_slot(
        input logic [lphs_pkg::IDX_W-1:0] p,
        input logic [lphs_pkg::CNT_W-1:0] n
    );
        logic [lphs_pkg::CNT_W:0] q;
        q = (lphs_pkg::CNT_W + 1)'(p) + 1'b1;
        if (q >= {1'b0, n}) begin
            return '0;
        end
        return q[lphs_pkg::IDX_W-1:0];
    endfunction

    // table memory
    t_entry                          r_mem [lphs_pkg::SLOTS];
    t_entry                          r_rd;
    logic                            mem_we;
    logic [lphs_pkg::IDX_W-1:0]      mem_waddr;
    t_entry                          mem_wdata;
    logic [lphs_pkg::IDX_W-1:0]      mem_raddr;

    // control and datapath registers
    t_state                          r_state;
    logic [lphs_pkg::CFG_W-1:0]      r_active;
    logic [lphs_pkg::CNT_W-1:0]      r_n;
    logic [lphs_pkg::CNT_W-1:0]      r_count;
    lphs_pkg::t_cmd                  r_cmd;
    logic [lphs_pkg::KEY_W-1:0]      r_key;
    logic [lphs_pkg::HASH_W-1:0]     r_hash;
    logic [lphs_pkg::IDX_W-1:0]      r_rem;
    logic [lphs_pkg::DIV_CW-1:0]     r_bit;
    logic [lphs_pkg::IDX_W-1:0]      r_home;
    logic [lphs_pkg::KEY_W-1:0]      r_pkey;
    logic [lphs_pkg::IDX_W-1:0]      r_mhome;
    logic [lphs_pkg::IDX_W-1:0]      r_ppos;
    logic [lphs_pkg::CNT_W-1:0]      r_pcnt;
    logic                            r_repair;
    logic [lphs_pkg::IDX_W-1:0]      r_rpos;
    logic [lphs_pkg::CNT_W-1:0]      r_rcnt;
    logic [lphs_pkg::IDX_W-1:0]      r_swp;
    logic [lphs_pkg::IDX_W-1:0]      r_swp_last;
    logic                            r_swp_rsp;
    lphs_pkg::t_status               r_res_status;
    logic [lphs_pkg::IDX_W-1:0]      r_res_idx;
    logic [lphs_pkg::KEY_W-1:0]      r_res_key;

    // output register
    logic                            r_o_valid;
    lphs_pkg::t_status               r_o_status;
    logic [lphs_pkg::IDX_W-1:0]      r_o_idx;
    logic [lphs_pkg::KEY_W-1:0]      r_o_key;
    logic [lphs_pkg::CNT_W-1:0]      r_o_count;

    // decode
    logic                            cfg_wr;
    logic                            accept;
    logic [lphs_pkg::IDX_W:0]        rem_sh;
    logic [lphs_pkg::REM_W-1:0]      rem_ext;
    logic                            rem_ge;
    logic [lphs_pkg::IDX_W-1:0]      rem_nxt;
    logic                            div_last;
    logic                            p_empty;
    logic                            p_hit;
    logic                            p_last;
    logic                            p_stop;
    logic [lphs_pkg::IDX_W-1:0]      p_dst;
    logic                            mv_needed;
    logic                            adv_done;
    logic                            out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == lphs_pkg::REG_ACTIVE_SLOTS);
    assign prdata = (paddr[2] == lphs_pkg::REG_ACTIVE_SLOTS)
                    ? lphs_pkg::DATA_W'(r_active) : '0;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);

    // remainder step: shift in one hash bit, subtract slot count if it fits
    assign rem_sh   = {r_rem, r_hash[lphs_pkg::HASH_W-1]};
    assign rem_ext  = lphs_pkg::REM_W'(rem_sh);
    assign rem_ge   = (rem_ext >= lphs_pkg::REM_W'(r_n));
    assign rem_nxt  = rem_ge ? lphs_pkg::IDX_W'(rem_ext - lphs_pkg::REM_W'(r_n))
                             : lphs_pkg::IDX_W'(rem_ext);
    assign div_last = (r_bit == lphs_pkg::DIV_CW'(lphs_pkg::HASH_W - 1));

    // shared probe compare on the slot just read
    assign p_empty   = !r_rd.valid;
    assign p_hit     = r_rd.valid && (r_rd.key == r_pkey);
    assign p_last    = (r_pcnt == (r_n - 1'b1));
    assign p_stop    = p_empty || p_hit || p_last;
    assign p_dst     = (p_empty || p_hit) ? r_ppos : '0;
    assign mv_needed = (p_dst != r_rpos);
    assign adv_done  = (r_rcnt == (r_n - 1'b1));

    assign out_free  = !r_o_valid || o_rsp.ready;

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ppos;
        mem_wdata = '0;
        mem_raddr = r_ppos;
        case (r_state)
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_swp;
            end
            S_RRD: begin
                mem_raddr = r_rpos;
            end
            S_PCHK: begin
                if (!r_repair) begin
                    if (r_cmd == lphs_pkg::CMD_INSERT && p_empty) begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.home  = r_home;
                        mem_wdata.key   = r_key;
                    end else if (r_cmd == lphs_pkg::CMD_REMOVE && p_hit) begin
                        mem_we = 1'b1;
                    end
                end else if (p_stop && mv_needed) begin
                    mem_we          = 1'b1;
                    mem_waddr       = p_dst;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.home  = r_mhome;
                    mem_wdata.key   = r_pkey;
                end
            end
            S_MOVE: begin
                mem_we    = 1'b1;
                mem_waddr = r_rpos;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_active   <= lphs_pkg::CFG_W'(lphs_pkg::RESET_SLOTS);
            r_n        <= sat_slots(lphs_pkg::CFG_W'(lphs_pkg::RESET_SLOTS));
            r_count    <= '0;
            r_swp      <= '0;
            r_swp_last <= lphs_pkg::IDX_W'(lphs_pkg::SLOTS - 1);
            r_swp_rsp  <= 1'b0;
            r_repair   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (r_swp == r_swp_last) begin
                        if (r_swp_rsp) begin
                            r_res_status <= lphs_pkg::ST_CLEARED;
                            r_res_idx    <= '0;
                            r_res_key    <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_swp <= r_swp + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd  <= lphs_pkg::t_cmd'(i_cmd.command);
                        r_key  <= i_cmd.key[lphs_pkg::KEY_W-1:0];
                        r_hash <= i_cmd.key_hash;
                        r_rem  <= '0;
                        r_bit  <= '0;
                        if (lphs_pkg::t_cmd'(i_cmd.command) == lphs_pkg::CMD_CLEAR) begin
                            r_count    <= '0;
                            r_swp      <= '0;
                            r_swp_last <= lphs_pkg::IDX_W'(r_n - 1'b1);
                            r_swp_rsp  <= 1'b1;
                            r_state    <= S_SWEEP;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_nxt;
                    r_hash <= {r_hash[lphs_pkg::HASH_W-2:0], 1'b0};
                    r_bit  <= r_bit + 1'b1;
                    if (div_last) begin
                        r_home   <= rem_nxt;
                        r_ppos   <= rem_nxt;
                        r_pkey   <= r_key;
                        r_pcnt   <= '0;
                        r_repair <= 1'b0;
                        r_state  <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (!p_stop) begin
                        r_ppos  <= next_slot(r_ppos, r_n);
                        r_pcnt  <= r_pcnt + 1'b1;
                        r_state <= S_PRD;
                    end else if (r_repair) begin
                        // re-probe of a run entry ended: move it or go on
                        if (mv_needed) begin
                            r_state <= S_MOVE;
                        end else if (adv_done) begin
                            r_state <= S_DONE;
                        end else begin
                            r_rpos  <= next_slot(r_rpos, r_n);
                            r_rcnt  <= r_rcnt + 1'b1;
                            r_state <= S_RRD;
                        end
                    end else begin
                        r_res_idx <= '0;
                        r_res_key <= '0;
                        r_state   <= S_DONE;
                        case (r_cmd)
                            lphs_pkg::CMD_INSERT: begin
                                if (p_hit) begin
                                    r_res_status <= lphs_pkg::ST_PRESENT;
                                    r_res_idx    <= r_ppos;
                                end else if (p_empty) begin
                                    r_res_status <= lphs_pkg::ST_INSERTED;
                                    r_res_idx    <= r_ppos;
                                    r_count      <= r_count + 1'b1;
                                end else begin
                                    r_res_status <= lphs_pkg::ST_FULL;
                                end
                            end
                            lphs_pkg::CMD_REMOVE: begin
                                if (p_hit) begin
                                    r_res_status <= lphs_pkg::ST_REMOVED;
                                    r_res_idx    <= r_ppos;
                                    r_res_key    <= r_rd.key;
                                    if (r_count != '0) begin
                                        r_count <= r_count - 1'b1;
                                    end
                                    // repair the run behind the new hole
                                    r_rpos  <= next_slot(r_ppos, r_n);
                                    r_rcnt  <= '0;
                                    r_state <= S_RRD;
                                end else begin
                                    r_res_status <= lphs_pkg::ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                if (p_hit) begin
                                    r_res_status <= lphs_pkg::ST_FOUND;
                                    r_res_idx    <= r_ppos;
                                    r_res_key    <= r_rd.key;
                                end else begin
                                    r_res_status <= lphs_pkg::ST_NOT_FOUND;
                                end
                            end
                        endcase
                    end
                end
                S_RRD: begin
                    r_state <= S_RCHK;
                end
                S_RCHK: begin
                    if (!r_rd.valid) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pkey   <= r_rd.key;
                        r_mhome  <= r_rd.home;
                        r_ppos   <= r_rd.home;
                        r_pcnt   <= '0;
                        r_repair <= 1'b1;
                        r_state  <= S_PRD;
                    end
                end
                S_MOVE: begin
                    if (adv_done) begin
                        r_state <= S_DONE;
                    end else begin
                        r_rpos  <= next_slot(r_rpos, r_n);
                        r_rcnt  <= r_rcnt + 1'b1;
                        r_state <= S_RRD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_idx    <= r_res_idx;
                        r_o_key    <= r_res_key;
                        r_o_count  <= r_count;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // register write empties the table with a full clearing pass
            if (cfg_wr) begin
                r_active   <= pwdata[lphs_pkg::CFG_W-1:0];
                r_n        <= sat_slots(pwdata[lphs_pkg::CFG_W-1:0]);
                r_count    <= '0;
                r_swp      <= '0;
                r_swp_last <= lphs_pkg::IDX_W'(lphs_pkg::SLOTS - 1);
                r_swp_rsp  <= 1'b0;
                r_state    <= S_SWEEP;
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.slot_index  = lphs_pkg::SLOT_IDX_W'(r_o_idx);
    assign o_rsp.stored_key  = lphs_pkg::SKEY_W'(r_o_key);
    assign o_rsp.entry_count = lphs_pkg::ECNT_W'(r_o_count);

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_n)
        else $error("entry count exceeds slots in use");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == S_SWEEP && r_count == '0 && !r_swp_rsp))
        else $error("register write did not start a clearing pass");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result word loaded outside the done state");
`endif

endmodule

[tb/sv/linear_probing_hash_set_top_tb.sv]
// linear_probing_hash_set_top_tb: self-checking bench for the linear probing hash set
// depends on lphs_pkg, lphs_cmd_if, lphs_rsp_if and linear_probing_hash_set_top
// predicts every result word from a software copy of the table and compares in order

module linear_probing_hash_set_top_tb;
    import lphs_pkg::*;

    // bench timing and limits
    localparam int CYCLE_LIMIT    = 4000000;
    localparam int SETTLE_CYCLES  = 2500;
    localparam int LONG_HOLD      = 600;
    localparam int REG_STRIDE     = 4;
    localparam int UNUSED_REG_IDX = 1;

    // outcome of a linear probe in the shadow table
    typedef enum logic [1:0] {
        SCAN_HIT,
        SCAN_EMPTY,
        SCAN_EXHAUSTED
    } t_scan;

    // one predicted result word
    typedef struct packed {
        t_status               status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [SKEY_W-1:0]     stored_key;
        logic [ECNT_W-1:0]     entry_count;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // apb register port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lphs_cmd_if cmd_ch();
    lphs_rsp_if rsp_ch();

    linear_probing_hash_set_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 0;
    end

    // shadow copy of the table, the slot count register and the entry count
    logic [KEY_W-1:0]  shadow_key [SLOTS];
    logic [IDX_W-1:0]  shadow_home [SLOTS];
    bit                shadow_used [SLOTS];
    int unsigned       shadow_count;
    logic [CFG_W-1:0]  slots_reg;

    // result words still owed by the block, oldest first
    t_reply replies_due[$];

    // keys the random traffic draws from, sized to the slot count in use
    logic [31:0] key_pool[$];

    int  fails;
    int  cycle_count;
    bit  gaps_on;
    int  hold_cycles;

    // ------------------------------------------------------------------
    // shadow table
    // ------------------------------------------------------------------

    // register value clamped to the legal slot range
    function automatic int unsigned slots_in_use();
        int unsigned n;
        n = slots_reg;
        if (n < MIN_SLOTS) n = MIN_SLOTS;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    function automatic void clear_table();
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        shadow_count = 0;
    endfunction

    // walk forward from the home slot until an equal key or a hole
    function automatic t_scan scan_slots(logic [KEY_W-1:0] k, int unsigned start,
                                         int unsigned n, output int unsigned found_at);
        int unsigned s;
        s = start % n;
        found_at = 0;
        for (int unsigned t = 0; t < n; t++) begin
            if (!shadow_used[s]) begin
                found_at = s;
                return SCAN_EMPTY;
            end
            if (shadow_key[s] == k) begin
                found_at = s;
                return SCAN_HIT;
            end
            s = (s + 1 >= n) ? 0 : s + 1;
        end
        return SCAN_EXHAUSTED;
    endfunction

    // after a removal, pull every entry of the following run back toward its home
    function automatic void close_gap(int unsigned hole, int unsigned n);
        int unsigned walk;
        int unsigned dest;
        walk = (hole + 1 >= n) ? 0 : hole + 1;
        for (int unsigned t = 0; t < n; t++) begin
            if (!shadow_used[walk]) break;
            void'(scan_slots(shadow_key[walk], shadow_home[walk], n, dest));
            if (dest != walk) begin
                shadow_key[dest]  = shadow_key[walk];
                shadow_home[dest] = shadow_home[walk];
                shadow_used[dest] = 1'b1;
                shadow_used[walk] = 1'b0;
            end
            walk = (walk + 1 >= n) ? 0 : walk + 1;
        end
    endfunction

    // apply one command to the shadow table and return the word it must produce
    function automatic t_reply predict_command(t_cmd c, logic [31:0] key,
                                               logic [31:0] key_hash);
        t_reply           r;
        t_scan            res;
        int unsigned      n;
        int unsigned      home;
        int unsigned      found_at;
        logic [KEY_W-1:0] k;
        r    = '0;
        k    = key[KEY_W-1:0];
        n    = slots_in_use();
        home = key_hash % n;
        if (c == CMD_CLEAR) begin
            clear_table();
            r.status = ST_CLEARED;
        end else begin
            res = scan_slots(k, home, n, found_at);
            if (c == CMD_INSERT) begin
                if (res == SCAN_HIT) begin
                    r.status     = ST_PRESENT;
                    r.slot_index = SLOT_IDX_W'(found_at);
                end else if (res == SCAN_EMPTY) begin
                    shadow_key[found_at]  = k;
                    shadow_home[found_at] = IDX_W'(home);
                    shadow_used[found_at] = 1'b1;
                    shadow_count++;
                    r.status     = ST_INSERTED;
                    r.slot_index = SLOT_IDX_W'(found_at);
                end else begin
                    // every slot in use holds another key
                    r.status = ST_FULL;
                end
            end else if (res != SCAN_HIT) begin
                r.status = ST_NOT_FOUND;
            end else if (c == CMD_REMOVE) begin
                r.stored_key = shadow_key[found_at];
                shadow_used[found_at] = 1'b0;
                if (shadow_count > 0) shadow_count--;
                close_gap(found_at, n);
                r.status     = ST_REMOVED;
                r.slot_index = SLOT_IDX_W'(found_at);
            end else begin
                r.stored_key = shadow_key[found_at];
                r.status     = ST_FOUND;
                r.slot_index = SLOT_IDX_W'(found_at);
            end
        end
        r.entry_count = ECNT_W'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one; none while idling is off
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // receiver ready, including the long hold-off that a test can request
    initial begin : result_drain
        int unsigned g;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                g = hold_cycles;
                hold_cycles = 0;
                repeat (g) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                g = pick_gap();
                repeat (g) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
                $error("result word with nothing expected: status %0d slot_index %0d",
                       rsp_ch.status, rsp_ch.slot_index);
                fails++;
            end else begin
                want = replies_due.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fails++;
                end
                if (rsp_ch.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           want.slot_index, rsp_ch.slot_index);
                    fails++;
                end
                if (rsp_ch.stored_key !== want.stored_key) begin
                    $error("stored_key: expected %h, got %h",
                           want.stored_key, rsp_ch.stored_key);
                    fails++;
                end
                if (rsp_ch.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp_ch.entry_count);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("linear_probing_hash_set_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // command side and register port
    // ------------------------------------------------------------------

    // offer one command word; valid stays high so back-to-back words need no drop
    task automatic send_command(t_cmd c, logic [31:0] key, logic [31:0] key_hash);
        int unsigned g;
        g = pick_gap();
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.key      <= key;
        cmd_ch.key_hash <= key_hash;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        replies_due.push_back(predict_command(c, key, key_hash));
    endtask

    // drop valid and wait for every owed result word
    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [DATA_W-1:0] value);
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a slot count write also empties the table
        if (idx == int'(REG_ACTIVE_SLOTS)) begin
            slots_reg = value[CFG_W-1:0];
            clear_table();
        end
        @(posedge i_clk);
    endtask

    task automatic read_reg(int idx, output logic [DATA_W-1:0] value);
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwrite  <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_slots_reg();
        logic [DATA_W-1:0] rd;
        read_reg(REG_ACTIVE_SLOTS, rd);
        if (rd !== DATA_W'(slots_reg)) begin
            $error("active_slots: expected %0d, got %0d", slots_reg, rd);
            fails++;
        end
    endtask

    // change the slot count while the block is idle, then read it back
    task automatic set_slots(logic [CFG_W-1:0] value);
        quiesce();
        write_reg(REG_ACTIVE_SLOTS, DATA_W'(value));
        check_slots_reg();
    endtask

    // a well-formed hash of a key, so repeated keys land on the same home
    function automatic logic [31:0] mix_hash(logic [31:0] k);
        logic [31:0] x;
        x = k ^ (k >> 16);
        x = x * 32'h7feb352d;
        x = x ^ (x >> 15);
        return x;
    endfunction

    // small tables get more keys than slots so they fill; large ones stay light
    task automatic fill_key_pool();
        int unsigned n;
        int unsigned size;
        n = slots_in_use();
        if (n <= 13) size = n + 3;
        else size = (n * 3 / 4 < 48) ? n * 3 / 4 : 48;
        key_pool.delete();
        repeat (size) key_pool.push_back($urandom);
    endtask

    // mostly pool keys with their own hash; some stray keys and some wrong hashes
    task automatic send_random_item();
        int unsigned r;
        int unsigned pick;
        t_cmd        c;
        logic [31:0] k;
        logic [31:0] h;
        r = $urandom_range(0, 99);
        if (r < 3) c = CMD_CLEAR;
        else if (r < 48) c = CMD_INSERT;
        else if (r < 70) c = CMD_REMOVE;
        else c = CMD_LOOKUP;
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        h = mix_hash(k);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            k = $urandom;
            h = $urandom;
        end else if (pick < 10) begin
            h = $urandom;
        end
        send_command(c, k, h);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // slot count register holds its reset value
    task automatic test_register_reset();
        check_slots_reg();
    endtask

    // basic commands at the reset slot count: collisions, wrap, repair, clear
    task automatic test_basic_commands();
        int unsigned last;
        last = slots_in_use() - 1;
        send_command(CMD_LOOKUP, 32'h0000_1234, 32'd7);       // empty table
        send_command(CMD_REMOVE, 32'h0000_1234, 32'd7);
        send_command(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0005, 32'h0000_0000); // collides, next slot
        send_command(CMD_INSERT, 32'h0000_0000, 32'h0000_0000); // duplicate
        send_command(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000); // neighbor moves back
        send_command(CMD_LOOKUP, 32'h0000_0005, 32'h0000_0000);
        // two keys homed on the last slot, the second wraps to the front
        send_command(CMD_INSERT, 32'hA5A5_A5A5, last);
        send_command(CMD_INSERT, 32'h5A5A_5A5A, last);
        send_command(CMD_REMOVE, 32'hA5A5_A5A5, last);
        send_command(CMD_LOOKUP, 32'h5A5A_5A5A, last);
        send_command(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_LOOKUP, 32'h0000_0005, 32'h0000_0000);
    endtask

    // slot count below the minimum, table full, unknown register
    task automatic test_full_table();
        logic [DATA_W-1:0] ones;
        ones = '1;
        set_slots('0);                                       // clamps to the minimum
        send_command(CMD_INSERT, 32'h0000_0011, 32'd0);
        send_command(CMD_INSERT, 32'h0000_0022, 32'd1);
        send_command(CMD_INSERT, 32'h0000_0033, 32'd2);
        send_command(CMD_INSERT, 32'h0000_0044, 32'd0);      // no room left
        send_command(CMD_LOOKUP, 32'h0000_0044, 32'd0);      // every slot probed
        send_command(CMD_REMOVE, 32'h0000_0044, 32'd0);
        send_command(CMD_INSERT, 32'h0000_0011, 32'd0);      // present in full table
        // write to an unused register index must leave the table alone
        quiesce();
        write_reg(UNUSED_REG_IDX, ones);
        check_slots_reg();
        send_command(CMD_LOOKUP, 32'h0000_0022, 32'd1);
        send_command(CMD_REMOVE, 32'h0000_0022, 32'd1);
        send_command(CMD_INSERT, 32'h0000_0044, 32'd0);
        send_command(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
    endtask

    // random traffic over a range of slot counts, the extremes among them
    task automatic test_random_phases();
        logic [CFG_W-1:0] settings[10];
        int unsigned      items;
        settings = '{11'd5, 11'd8, 11'd13, 11'd31, 11'd61, 11'd1, 11'd2047,
                     11'd1500, 11'd1024, 11'd1021};
        foreach (settings[i]) begin
            set_slots(settings[i]);
            fill_key_pool();
            items = (slots_in_use() > 100) ? 60 : 120;
            repeat (items) send_random_item();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering words
    task automatic test_receiver_hold();
        set_slots(11'd7);
        fill_key_pool();
        gaps_on = 1'b0;
        hold_cycles = LONG_HOLD;
        repeat (24) send_random_item();
        gaps_on = 1'b1;
        repeat (20) send_random_item();
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        set_slots(11'd11);
        fill_key_pool();
        repeat (30) send_random_item();
        quiesce();
        repeat (30) send_random_item();
    endtask

    // a stretch with no gaps on either side
    task automatic test_no_idling();
        set_slots(11'd17);
        fill_key_pool();
        gaps_on = 1'b0;
        repeat (60) send_random_item();
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial begin : run
        fails       = 0;
        cycle_count = 0;
        gaps_on     = 1'b1;
        hold_cycles = 0;
        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.command  <= CMD_INSERT;
        cmd_ch.key      <= '0;
        cmd_ch.key_hash <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        // shadow state after reset
        slots_reg = CFG_W'(RESET_SLOTS);
        clear_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_basic_commands();
        test_full_table();
        test_random_phases();
        test_receiver_hold();
        test_sender_pause();
        test_no_idling();

        // everything owed must arrive, and nothing more after it
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("linear_probing_hash_set_top_tb: clean");
        end else begin
            $display("linear_probing_hash_set_top_tb: errors");
        end
        $finish;
    end

endmodule
